// ----- sv/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// Sparse key table package
// Shared types, codes, sizes and the occupancy priority encoder used by the
// front, queue and back of the sparse key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  // Fixed field widths of the stream payload.
  localparam int KEY_BITS  = 16;
  localparam int DATA_BITS = 32;
  localparam int MARK_BITS = 11;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEFAULT      = 1024;
  localparam int VALUE_BITS_DEFAULT = 32;

  // Occupancy is kept as rows of 32 flags, one flag per key.
  localparam int OCC_ROW_BITS = 32;
  localparam int OCC_POS_BITS = 5;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Operation codes carried on the input tuser.
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Command kinds as classified by the front.
  typedef enum logic [2:0] {
    KIND_READ,
    KIND_READ_OOR,
    KIND_WRITE_OOR,
    KIND_SET,
    KIND_DELETE
  } skt_kind_t;

  // One classified command.
  typedef struct packed {
    skt_kind_t             kind;
    logic [KEY_BITS-1:0]   key;
    logic [DATA_BITS-1:0]  value;
  } skt_cmd_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN
  } skt_state_t;

  // Result of the priority encoder over one occupancy row.
  typedef struct packed {
    logic                    found;
    logic [OCC_POS_BITS-1:0] pos;
  } skt_hit_t;

  // Position of the highest set flag in an occupancy row.
  function automatic skt_hit_t highest_set(input logic [OCC_ROW_BITS-1:0] row);
    skt_hit_t res;
    res.found = 1'b0;
    res.pos   = '0;
    for (int i = 0; i < OCC_ROW_BITS; i++) begin
      if (row[i]) begin
        res.found = 1'b1;
        res.pos   = OCC_POS_BITS'(i);
      end
    end
    return res;
  endfunction

endpackage

// ----- sv/skt_front.sv -----
// ----------------------------------------------------------------------------
// Sparse key table front end
// Accepts input transfers and classifies each one into a command kind:
// read, out-of-range read or write, fill, or delete.
// ----------------------------------------------------------------------------
module skt_front #(
  parameter int DEPTH      = skt_pkg::DEPTH_DEFAULT,
  parameter int VALUE_BITS = skt_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [skt_pkg::KEY_BITS-1:0]  key,
  input  logic [skt_pkg::DATA_BITS-1:0] write_value,
  input  logic [(VALUE_BITS < skt_pkg::DATA_BITS ? VALUE_BITS
                 : skt_pkg::DATA_BITS)-1:0] empty_value,
  input  logic                          enable,
  input  logic                          q_ready,
  output logic                          q_push,
  output skt_pkg::skt_cmd_t             q_cmd
);

  localparam int SW = (VALUE_BITS < skt_pkg::DATA_BITS) ? VALUE_BITS : skt_pkg::DATA_BITS;

  logic in_range;
  logic is_empty;

  // Accept only after the clearing pass and while the queue has room.
  assign in_ready = enable && q_ready;
  assign q_push   = in_valid && in_ready;

  assign in_range = ({1'b0, key} < (skt_pkg::KEY_BITS + 1)'(DEPTH));
  assign is_empty = (write_value[SW-1:0] == empty_value);

  // Classify the transfer.
  always_comb begin
    q_cmd.key   = key;
    q_cmd.value = write_value;
    if (func == skt_pkg::FUNC_READ) begin
      q_cmd.kind = in_range ? skt_pkg::KIND_READ : skt_pkg::KIND_READ_OOR;
    end else if (!in_range) begin
      q_cmd.kind = skt_pkg::KIND_WRITE_OOR;
    end else begin
      q_cmd.kind = is_empty ? skt_pkg::KIND_DELETE : skt_pkg::KIND_SET;
    end
  end

endmodule

// ----- sv/skt_queue.sv -----
// ----------------------------------------------------------------------------
// Sparse key table command queue
// A short FIFO of classified commands that lets the front and the back
// stall independently.
// ----------------------------------------------------------------------------
module skt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  skt_pkg::skt_cmd_t push_cmd,
  output logic              push_ready,
  input  logic              pop,
  output logic              pop_valid,
  output skt_pkg::skt_cmd_t pop_cmd
);

  localparam int PW = (skt_pkg::QUEUE_DEPTH > 1) ? $clog2(skt_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(skt_pkg::QUEUE_DEPTH + 1);

  skt_pkg::skt_cmd_t slot_r [skt_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign push_ready = (count_r != CW'(skt_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(skt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(skt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- sv/skt_back.sv -----
// ----------------------------------------------------------------------------
// Sparse key table back end
// Owns the value and occupancy memories and the high-water mark, carries
// out one command at a time and holds the result in the output register.
// After reset it clears the occupancy memory one row per cycle.
// ----------------------------------------------------------------------------
module skt_back #(
  parameter int DEPTH      = skt_pkg::DEPTH_DEFAULT,
  parameter int VALUE_BITS = skt_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [(VALUE_BITS < skt_pkg::DATA_BITS ? VALUE_BITS
                 : skt_pkg::DATA_BITS)-1:0] empty_value,
  output logic                           ready,
  input  logic                           q_valid,
  input  skt_pkg::skt_cmd_t              q_cmd,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [skt_pkg::DATA_BITS-1:0]  out_read_value,
  output logic [skt_pkg::MARK_BITS-1:0]  out_high_water,
  output logic                           out_out_of_range
);

  localparam int SW   = (VALUE_BITS < skt_pkg::DATA_BITS) ? VALUE_BITS : skt_pkg::DATA_BITS;
  localparam int AW   = $clog2(DEPTH);
  localparam int MW   = $clog2(DEPTH + 1);
  localparam int ROWS = (DEPTH + skt_pkg::OCC_ROW_BITS - 1) / skt_pkg::OCC_ROW_BITS;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PB   = skt_pkg::OCC_POS_BITS;
  localparam int KB   = skt_pkg::KEY_BITS;

  // Memories.
  logic [skt_pkg::OCC_ROW_BITS-1:0] occ_mem [ROWS];
  logic [SW-1:0]                    val_mem [DEPTH];

  // Registers.
  skt_pkg::skt_state_t              state_r, state_nxt;
  skt_pkg::skt_cmd_t                cmd_r;
  logic [MW-1:0]                    mark_r, mark_nxt;
  logic [RW-1:0]                    scan_row_r, scan_row_nxt;
  logic [RW-1:0]                    clr_row_r, clr_row_nxt;
  logic [skt_pkg::OCC_ROW_BITS-1:0] occ_rd_r;
  logic [SW-1:0]                    val_rd_r;
  logic                             out_valid_r, out_valid_nxt;
  logic [SW-1:0]                    out_val_r;
  logic [MW-1:0]                    out_mark_r;
  logic                             out_oor_r;

  // Datapath signals.
  logic [KB-1:0]                    cmd_row_w, q_row_w;
  logic [RW-1:0]                    cmd_row, q_row, base_row;
  logic [PB-1:0]                    cmd_pos;
  logic [skt_pkg::OCC_ROW_BITS-1:0] cmd_mask, occ_mod, pe_row;
  logic [KB:0]                      key_plus1;
  logic [MW-1:0]                    kp1;
  logic [RW+PB:0]                   hit_sum;
  logic [MW-1:0]                    hit_mark;
  skt_pkg::skt_hit_t                hit;
  logic                             out_busy;
  logic                             top_del;
  logic                             row_zero;
  logic                             scan_go;

  // Control outputs of the sequencer.
  logic                             emit;
  logic [SW-1:0]                    res_val;
  logic                             res_oor;
  logic                             rd_en;
  logic [RW-1:0]                    rd_row;
  logic [AW-1:0]                    rd_idx;
  logic                             occ_we;
  logic [RW-1:0]                    occ_waddr;
  logic [skt_pkg::OCC_ROW_BITS-1:0] occ_wdata;
  logic                             val_we;

  // Row, position and index of the current command and the queue head.
  assign cmd_row_w = cmd_r.key >> PB;
  assign q_row_w   = q_cmd.key >> PB;
  assign cmd_row   = cmd_row_w[RW-1:0];
  assign q_row     = q_row_w[RW-1:0];
  assign cmd_pos   = cmd_r.key[PB-1:0];
  assign cmd_mask  = skt_pkg::OCC_ROW_BITS'(1) << cmd_pos;
  assign key_plus1 = {1'b0, cmd_r.key} + (KB + 1)'(1);
  assign kp1       = MW'(key_plus1);

  // Occupancy row after this command's change.
  assign occ_mod = (cmd_r.kind == skt_pkg::KIND_SET) ? (occ_rd_r | cmd_mask)
                                                     : (occ_rd_r & ~cmd_mask);

  // Highest occupied key in the row under inspection.
  assign pe_row   = (state_r == skt_pkg::ST_SCAN) ? occ_rd_r : occ_mod;
  assign base_row = (state_r == skt_pkg::ST_SCAN) ? scan_row_r : cmd_row;
  assign hit      = skt_pkg::highest_set(pe_row);
  assign hit_sum  = {1'b0, base_row, hit.pos} + (RW + PB + 1)'(1);
  assign hit_mark = MW'(hit_sum);
  assign row_zero = (base_row == '0);

  assign out_busy = out_valid_r && !out_ready;
  assign top_del  = (mark_r == kp1);
  assign scan_go  = (cmd_r.kind == skt_pkg::KIND_DELETE) && top_del && !hit.found && !row_zero;
  assign ready    = (state_r != skt_pkg::ST_CLEAR);

  // Sequencer outputs and datapath control.
  always_comb begin
    q_pop        = 1'b0;
    emit         = 1'b0;
    res_val      = '0;
    res_oor      = 1'b0;
    rd_en        = 1'b0;
    rd_row       = q_row;
    rd_idx       = q_cmd.key[AW-1:0];
    occ_we       = 1'b0;
    occ_waddr    = cmd_row;
    occ_wdata    = occ_mod;
    val_we       = 1'b0;
    mark_nxt     = mark_r;
    scan_row_nxt = scan_row_r;
    clr_row_nxt  = clr_row_r;
    unique case (state_r)
      skt_pkg::ST_CLEAR: begin
        occ_we      = 1'b1;
        occ_waddr   = clr_row_r;
        occ_wdata   = '0;
        clr_row_nxt = clr_row_r + RW'(1);
      end
      skt_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          rd_en = 1'b1;
        end
      end
      skt_pkg::ST_ACCESS: begin
        if (!out_busy) begin
          unique case (cmd_r.kind)
            skt_pkg::KIND_READ: begin
              emit    = 1'b1;
              res_val = occ_rd_r[cmd_pos] ? val_rd_r : empty_value;
            end
            skt_pkg::KIND_READ_OOR: begin
              emit    = 1'b1;
              res_val = empty_value;
              res_oor = 1'b1;
            end
            skt_pkg::KIND_WRITE_OOR: begin
              emit    = 1'b1;
              res_oor = 1'b1;
            end
            skt_pkg::KIND_SET: begin
              emit     = 1'b1;
              occ_we   = 1'b1;
              val_we   = 1'b1;
              mark_nxt = (kp1 > mark_r) ? kp1 : mark_r;
            end
            skt_pkg::KIND_DELETE: begin
              occ_we = 1'b1;
              if (!top_del) begin
                emit = 1'b1;
              end else if (hit.found) begin
                emit     = 1'b1;
                mark_nxt = hit_mark;
              end else if (row_zero) begin
                emit     = 1'b1;
                mark_nxt = '0;
              end else begin
                // Start the downward search on the row below.
                rd_en        = 1'b1;
                rd_row       = cmd_row - RW'(1);
                scan_row_nxt = cmd_row - RW'(1);
              end
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      skt_pkg::ST_SCAN: begin
        if (hit.found) begin
          if (!out_busy) begin
            emit     = 1'b1;
            mark_nxt = hit_mark;
          end
        end else if (row_zero) begin
          if (!out_busy) begin
            emit     = 1'b1;
            mark_nxt = '0;
          end
        end else begin
          rd_en        = 1'b1;
          rd_row       = scan_row_r - RW'(1);
          scan_row_nxt = scan_row_r - RW'(1);
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      skt_pkg::ST_CLEAR: begin
        if (clr_row_r == RW'(ROWS - 1)) begin
          state_nxt = skt_pkg::ST_IDLE;
        end
      end
      skt_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_nxt = skt_pkg::ST_ACCESS;
        end
      end
      skt_pkg::ST_ACCESS: begin
        if (!out_busy) begin
          state_nxt = scan_go ? skt_pkg::ST_SCAN : skt_pkg::ST_IDLE;
        end
      end
      skt_pkg::ST_SCAN: begin
        if (emit) begin
          state_nxt = skt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = skt_pkg::ST_CLEAR;
      end
    endcase
  end

  assign out_valid_nxt = out_busy || emit;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skt_pkg::ST_CLEAR;
      clr_row_r   <= '0;
      mark_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      mark_r      <= mark_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Command, scan row and result payload.
  always_ff @(posedge clk) begin
    scan_row_r <= scan_row_nxt;
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (emit) begin
      out_val_r  <= res_val;
      out_mark_r <= mark_nxt;
      out_oor_r  <= res_oor;
    end
  end

  // Occupancy memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    if (rd_en) begin
      occ_rd_r <= occ_mem[rd_row];
    end
  end

  // Value memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[cmd_r.key[AW-1:0]] <= cmd_r.value[SW-1:0];
    end
    if (rd_en) begin
      val_rd_r <= val_mem[rd_idx];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_value   = skt_pkg::DATA_BITS'(out_val_r);
  assign out_high_water   = skt_pkg::MARK_BITS'(out_mark_r);
  assign out_out_of_range = out_oor_r;

endmodule

// ----- sv/sparse_key_table_with_high_water.sv -----
// ----------------------------------------------------------------------------
// Sparse key table with high-water mark
// A directly indexed key/value table that tracks one plus its highest
// occupied key and reports it with every result.
// ----------------------------------------------------------------------------
// Each input transfer (a read or a write) yields exactly one result transfer,
// in order. A read, a fill, an out-of-range access and a delete below the top
// entry each pass through the registered read of the value and occupancy
// memories followed by the update. Deleting the top entry adds a downward
// search, one 32-key occupancy row at a time, from the row below the deleted
// key's row down to row 0 at most. After reset the occupancy memory is cleared
// one row per cycle, during which in_tready stays low; empty_value can be
// written at any time the block holds no work.
module sparse_key_table_with_high_water #(
  parameter int DEPTH      = skt_pkg::DEPTH_DEFAULT,
  parameter int VALUE_BITS = skt_pkg::VALUE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: empty_value.
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] key, [47:16] write_value
  input  logic        in_tuser,   // [0] func
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] read_value, [42:32] high_water, [47:43] zero
  output logic        out_tuser   // [0] out_of_range
);

  localparam int SW = (VALUE_BITS < skt_pkg::DATA_BITS) ? VALUE_BITS : skt_pkg::DATA_BITS;

  logic [SW-1:0]                    empty_r;
  logic                             back_ready;
  logic                             q_ready, q_push, q_pop, q_valid;
  skt_pkg::skt_cmd_t                push_cmd, head_cmd;
  logic [skt_pkg::DATA_BITS-1:0]    res_val;
  logic [skt_pkg::MARK_BITS-1:0]    res_mark;
  logic                             res_oor;

  // Empty-value register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_r <= '0;
    end else if (cfg_we) begin
      empty_r <= cfg_wdata[SW-1:0];
    end
  end

  skt_front #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .func        (in_tuser),
    .key         (in_tdata[15:0]),
    .write_value (in_tdata[47:16]),
    .empty_value (empty_r),
    .enable      (back_ready),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  skt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (head_cmd)
  );

  skt_back #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .empty_value      (empty_r),
    .ready            (back_ready),
    .q_valid          (q_valid),
    .q_cmd            (head_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_read_value   (res_val),
    .out_high_water   (res_mark),
    .out_out_of_range (res_oor)
  );

  // Pack the result fields.
  assign out_tdata = {5'd0, res_mark, res_val};
  assign out_tuser = res_oor;

endmodule

// ----- sv/skt_checker.sv -----
// ----------------------------------------------------------------------------
// Sparse key table port checker
// Watches the top-level ports for stalled and spurious results, capacity,
// reset behavior and the mark bound, and is attached to the top level by a bind.
// ----------------------------------------------------------------------------
module skt_checker #(
  parameter int DEPTH = skt_pkg::DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser
);

  // Queue slots, the command in the back end and the output register.
  localparam int PEND_MAX = skt_pkg::QUEUE_DEPTH + 2;

  logic [2:0] pend_r, pend_nxt;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  // Count transfers taken in but not yet answered.
  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = pend_r + 3'd1;
    end else if (out_xfer && !in_xfer) begin
      pend_nxt = pend_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // No result is shown without an input transfer waiting for it.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 3'd0)
    else $error("result without a pending input transfer");

  // The block never holds more work than its queue and registers allow.
  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'(PEND_MAX))
    else $error("more transfers in flight than storage allows");

  // Input is refused right after reset, when the occupancy memory clearing starts.
  a_reset_block: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input accepted right after reset");

  // The mark never exceeds the table depth.
  a_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (DEPTH > 2047) || (out_tdata[42:32] <= 11'(DEPTH)))
    else $error("high-water mark beyond table depth");

endmodule

bind sparse_key_table_with_high_water skt_checker #(.DEPTH(DEPTH)) u_skt_checker (.*);

// ----- bench/tb_sparse_key_table_with_high_water.sv -----
// ----------------------------------------------------------------------------
// Sparse key table with high-water mark: self-checking testbench
// Streams reads and writes into the table through a bursty sender, drains the
// results through a stalling receiver, and compares every result transfer
// field by field against a behavioral copy of the table, its occupancy and
// its high-water mark. Runs a directed pass over the boundary cases and then
// random traffic under several empty values, 0 and all ones among them.
// ----------------------------------------------------------------------------
module tb_sparse_key_table_with_high_water;
  import skt_pkg::*;

  localparam int TABLE_DEPTH = DEPTH_DEFAULT;

  // One table request and one table response as they travel the streams.
  typedef struct packed {
    logic                 func;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] wval;
  } table_op_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] read_value;
    logic [MARK_BITS-1:0] high_water;
    logic                 out_of_range;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // [15:0] key, [47:16] write_value
  logic        in_tuser = 1'b0; // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // [31:0] read_value, [42:32] high_water, [47:43] zero
  logic        out_tuser;       // [0] out_of_range

  sparse_key_table_with_high_water #(
    .DEPTH      (TABLE_DEPTH),
    .VALUE_BITS (VALUE_BITS_DEFAULT)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // Requests waiting to be sent and responses waiting to arrive.
  table_op_t     pending_ops[$];
  table_result_t expected_results[$];
  table_op_t     cur_op;
  bit            in_taken = 1'b0;
  int            fail_count = 0;

  // Behavioral copy of the table.
  logic [DATA_BITS-1:0] tbl_empty = '0;
  logic [DATA_BITS-1:0] tbl_values[TABLE_DEPTH];
  bit                   tbl_occupied[TABLE_DEPTH];
  int unsigned          tbl_mark = 0;

  // Stimulus bookkeeping: which in-range keys have had a value stored.
  logic [DATA_BITS-1:0] gen_empty = '0;
  logic [DATA_BITS-1:0] past_empty = '0;
  bit                   gen_written[TABLE_DEPTH];
  logic [KEY_BITS-1:0]  written_keys[$];

  // Sender burst state and receiver stall pattern.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [5:0]  stall_step = '0;

  // Apply one request to the table copy and return the response it yields.
  function automatic table_result_t apply_table_op(input table_op_t op);
    table_result_t res;
    bit            in_range;
    in_range = op.key < TABLE_DEPTH;
    res = '0;
    res.out_of_range = !in_range;
    if (op.func == FUNC_READ) begin
      res.read_value = (in_range && tbl_occupied[op.key]) ? tbl_values[op.key] : tbl_empty;
    end else if (in_range) begin
      tbl_values[op.key] = op.wval;
      if (op.wval == tbl_empty) begin
        tbl_occupied[op.key] = 1'b0;
        // Removing the top entry walks the mark down past empty entries.
        if (tbl_mark == op.key + 1) begin
          while (tbl_mark > 0 && !tbl_occupied[tbl_mark - 1]) tbl_mark--;
        end
      end else begin
        tbl_occupied[op.key] = 1'b1;
        if (op.key + 1 > tbl_mark) tbl_mark = op.key + 1;
      end
    end
    res.high_water = MARK_BITS'(tbl_mark);
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [DATA_BITS-1:0] want,
                                      input logic [DATA_BITS-1:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endfunction

  // Queue one request and remember which keys now hold a stored value.
  function automatic void queue_op(input logic func, input logic [KEY_BITS-1:0] key,
                                   input logic [DATA_BITS-1:0] wval);
    table_op_t op;
    op.func = func;
    op.key  = key;
    op.wval = wval;
    pending_ops.push_back(op);
    if (func == FUNC_WRITE && key < TABLE_DEPTH && !gen_written[key]) begin
      gen_written[key] = 1'b1;
      written_keys.push_back(key);
    end
  endfunction

  function automatic logic [DATA_BITS-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return past_empty;
      1:       return '1;
      2:       return '0;
      default: return DATA_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [KEY_BITS-1:0] random_far_key();
    if ($urandom_range(0, 3) == 0) return '1;
    return KEY_BITS'($urandom_range(TABLE_DEPTH, 65535));
  endfunction

  // Random traffic clustered in a sliding key window so that fills and
  // deletes keep hitting the top entry and the mark search crosses rows.
  task automatic queue_random_ops(input int count);
    int unsigned         base;
    int unsigned         span;
    int unsigned         sel;
    logic [KEY_BITS-1:0] key;
    base = 0;
    span = 1;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        span = $urandom_range(4, 160);
        case ($urandom_range(0, 3))
          0:       base = 0;
          1:       base = TABLE_DEPTH - span;
          default: base = $urandom_range(0, TABLE_DEPTH - span);
        endcase
      end
      key = KEY_BITS'(base + $urandom_range(0, span - 1));
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        // Out-of-range noise, reads and writes alike.
        queue_op(sel[0] ? FUNC_WRITE : FUNC_READ, random_far_key(), DATA_BITS'($urandom));
      end else if (sel < 13) begin
        queue_op(FUNC_WRITE, KEY_BITS'($urandom_range(0, TABLE_DEPTH - 1)), random_value());
      end else if (sel < 45) begin
        queue_op(FUNC_WRITE, key, random_value());
      end else if (sel < 65) begin
        queue_op(FUNC_WRITE, key, gen_empty);
      end else begin
        // Reads stay on keys that have held a value, or go out of range.
        if (!gen_written[key]) begin
          if (written_keys.size() > 0)
            key = written_keys[$urandom_range(0, written_keys.size() - 1)];
          else
            key = random_far_key();
        end
        queue_op(FUNC_READ, key, DATA_BITS'($urandom));
      end
    end
  endtask

  // Sampled at the rising edge, where the sender's outputs are settled.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_ops.size() != 0 || in_tvalid || expected_results.size() != 0);
  endtask

  task automatic set_empty_value(input logic [DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    tbl_empty  = value;
    past_empty = gen_empty;
    gen_empty  = value;
  endtask

  // Sender: takes requests from the queue in bursts separated by gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_taken || !in_tvalid) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        cur_op = pending_ops.pop_front();
        in_tuser  <= cur_op.func;
        in_tdata  <= {cur_op.wval, cur_op.key};
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // Receiver: steps through a 16-entry ready pattern, reloaded each time the 6-bit step counter wraps.
  always @(negedge clk) begin
    if (stall_step == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pattern = 16'hFFFF;
        1:       stall_pattern = 16'($urandom) | 16'h0001;
        2:       stall_pattern = 16'h0101;
        default: stall_pattern = 16'($urandom) & 16'($urandom) | 16'h0001;
      endcase
    end
    out_tready <= stall_pattern[stall_step[3:0]];
    stall_step = stall_step + 1'b1;
  end

  // Monitor: predicts on each accepted request, checks each response transfer.
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(apply_table_op(cur_op));
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $error("result transfer with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("read_value", want.read_value, out_tdata[31:0]);
          check_field("high_water", DATA_BITS'(want.high_water), DATA_BITS'(out_tdata[42:32]));
          check_field("out_of_range", DATA_BITS'(want.out_of_range), DATA_BITS'(out_tuser));
        end
      end
    end
  end

  // Main sequence: reset, directed cases, then random phases.
  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    set_empty_value('0);

    // Out-of-range read and ignored out-of-range write.
    queue_op(FUNC_READ, 16'hFFFF, 32'h0);
    queue_op(FUNC_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
    // Fills at both ends of the table.
    queue_op(FUNC_WRITE, 16'd0, 32'hFFFF_FFFF);
    queue_op(FUNC_READ, 16'd0, 32'h0);
    queue_op(FUNC_WRITE, 16'(TABLE_DEPTH - 1), 32'h1);
    queue_op(FUNC_READ, 16'(TABLE_DEPTH - 1), 32'hFFFF_FFFF);
    // Delete below the top, then read the cleared entry.
    queue_op(FUNC_WRITE, 16'd40, 32'hA5A5_A5A5);
    queue_op(FUNC_WRITE, 16'd40, 32'h0);
    queue_op(FUNC_READ, 16'd40, 32'h0);
    // Delete of an entry that was never occupied.
    queue_op(FUNC_WRITE, 16'd500, 32'h0);
    // Delete of the top entry: the mark falls across every row to key 0.
    queue_op(FUNC_WRITE, 16'(TABLE_DEPTH - 1), 32'h0);
    queue_op(FUNC_WRITE, 16'd0, 32'h0);
    // First key past the end of the table.
    queue_op(FUNC_WRITE, 16'(TABLE_DEPTH), 32'h5);
    queue_op(FUNC_READ, 16'(TABLE_DEPTH), 32'h0);
    // Small stack of entries emptied from the top down to nothing.
    queue_op(FUNC_WRITE, 16'd2, 32'h1234_5678);
    queue_op(FUNC_WRITE, 16'd1, 32'h7);
    queue_op(FUNC_WRITE, 16'd2, 32'h0);
    queue_op(FUNC_READ, 16'd1, 32'h0);
    queue_op(FUNC_WRITE, 16'd1, 32'h0);
    // Entry whose value becomes the empty value in the next phase.
    queue_op(FUNC_WRITE, 16'd3, 32'h55);
    wait_idle();

    // A stored value equal to the new empty value stays occupied.
    set_empty_value(32'h55);
    queue_op(FUNC_READ, 16'd3, 32'h0);
    queue_op(FUNC_READ, 16'd1, 32'h0);
    queue_op(FUNC_WRITE, 16'd3, 32'h55);
    queue_op(FUNC_READ, 16'd3, 32'h0);
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_empty_value('1);
        2:       set_empty_value('0);
        default: set_empty_value(DATA_BITS'($urandom));
      endcase
      queue_random_ops(200);
      wait_idle();
    end

    // Leave room for any stray result after the last one.
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("** sparse_key_table_with_high_water: PASSED **");
    else
      $display("** sparse_key_table_with_high_water: FAILED **");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #4000000;
    $display("** sparse_key_table_with_high_water: FAILED **");
    $finish;
  end

endmodule
